[hdl/irts_pkg.sv]
// ----------------------------------------------------------------------------
// irts_pkg
// Types and codes shared by the I2C register transaction sequencer.
// ----------------------------------------------------------------------------
package irts_pkg;

	localparam int unsigned LENGTH_BITS = 16;

	localparam logic [7:0] ST_MASK         = 8'hF8;
	localparam logic [7:0] ST_START        = 8'h08;
	localparam logic [7:0] ST_REP_START    = 8'h10;
	localparam logic [7:0] ST_TX_ADR_ACK   = 8'h18;
	localparam logic [7:0] ST_TX_DATA_ACK  = 8'h28;
	localparam logic [7:0] ST_RX_ADR_ACK   = 8'h40;
	localparam logic [7:0] ST_RX_DATA_ACK  = 8'h50;
	localparam logic [7:0] ST_RX_DATA_NACK = 8'h58;

	localparam logic [2:0] RETRY_RESET   = 3'd3;
	localparam logic [7:0] TIMEOUT_RESET = 8'd50;

	typedef enum logic [0:0] {
		CFG_RETRY_LIMIT   = 1'b0,
		CFG_TIMEOUT_TICKS = 1'b1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		KIND_CMD  = 2'd0,
		KIND_BYTE = 2'd1,
		KIND_DONE = 2'd2,
		KIND_TICK = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ACT_NONE    = 3'd0,
		ACT_START   = 3'd1,
		ACT_SEND    = 3'd2,
		ACT_RX_ACK  = 3'd3,
		ACT_RX_NACK = 3'd4,
		ACT_STOP    = 3'd5
	} act_t;

	typedef enum logic [3:0] {
		PH_IDLE       = 4'd0,
		PH_SELW_START = 4'd1,
		PH_SELW_ADDR  = 4'd2,
		PH_SELW_STOP  = 4'd3,
		PH_REG        = 4'd4,
		PH_SELR_START = 4'd5,
		PH_SELR_ADDR  = 4'd6,
		PH_SELR_STOP  = 4'd7,
		PH_RX         = 4'd8,
		PH_NEED       = 4'd9,
		PH_TX         = 4'd10,
		PH_FINAL_STOP = 4'd11
	} phase_t;

	typedef struct packed {
		kind_t                  kind;
		logic                   is_read;
		logic [6:0]             dev_addr;
		logic [1:0]             addr_bytes;
		logic [15:0]            reg_addr;
		logic [LENGTH_BITS-1:0] length;
		logic [7:0]             write_byte;
		logic [7:0]             bus_status;
		logic [7:0]             bus_rx_byte;
	} in_item_t;

	typedef struct packed {
		act_t       action;
		logic [7:0] action_byte;
		logic       rx_valid;
		logic [7:0] rx_data;
		logic       need_data;
		logic       done_res;
		logic       ok;
	} out_item_t;

endpackage

[hdl/i2c_register_transaction_sequencer.sv]
// ----------------------------------------------------------------------------
// i2c_register_transaction_sequencer
// Register read/write sequencer driving a byte-level I2C bus engine.
// Path: one input register, one decode pass over the phase state, one
// result register.
// Throughput: one input transfer per cycle, sustained, when out_stall is low.
// Reset: arst_n clears phase, counters and holding state to zero and loads
// retry_limit 3 and timeout_ticks 50.
// ----------------------------------------------------------------------------
module i2c_register_transaction_sequencer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  irts_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output irts_pkg::out_item_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  irts_pkg::cfg_idx_t  cfg_index,
	input  logic [7:0]          cfg_data
);
	import irts_pkg::*;

	logic                   valid_s1;
	in_item_t               item_s1;
	logic                   out_valid_q;
	out_item_t              out_data_q;
	logic                   advance;

	logic [2:0]             retry_limit_q;
	logic [7:0]             timeout_ticks_q;

	phase_t                 phase_q, phase_d;
	logic [2:0]             tries_q, tries_d;
	logic [7:0]             wait_q, wait_d;
	logic [LENGTH_BITS-1:0] bytes_q, bytes_d;
	logic [1:0]             abl_q, abl_d;
	logic [6:0]             dev_q, dev_d;
	logic [15:0]            reg_q, reg_d;
	logic                   dir_q, dir_d;
	logic                   failed_q, failed_d;

	logic                   has_res;
	out_item_t              res;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retry_limit_q   <= RETRY_RESET;
			timeout_ticks_q <= TIMEOUT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_RETRY_LIMIT:   retry_limit_q   <= cfg_data[2:0];
				CFG_TIMEOUT_TICKS: timeout_ticks_q <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && has_res) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_res) begin
			out_data_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			tries_q  <= '0;
			wait_q   <= '0;
			bytes_q  <= '0;
			abl_q    <= '0;
			dev_q    <= '0;
			reg_q    <= '0;
			dir_q    <= 1'b0;
			failed_q <= 1'b0;
		end else if (advance) begin
			phase_q  <= phase_d;
			tries_q  <= tries_d;
			wait_q   <= wait_d;
			bytes_q  <= bytes_d;
			abl_q    <= abl_d;
			dev_q    <= dev_d;
			reg_q    <= reg_d;
			dir_q    <= dir_d;
			failed_q <= failed_d;
		end
	end

	always_comb begin
		logic [7:0]             st;
		logic [2:0]             lim_tries;
		logic [7:0]             lim_to;
		logic [7:0]             wait_inc;
		logic [2:0]             tries_dec;
		logic [LENGTH_BITS-1:0] bytes_dec;
		logic [1:0]             abl_dec;
		logic                   waiting;
		logic                   fire;
		logic                   timed;
		logic                   sel_fail;
		logic                   fail;
		logic                   rd;

		phase_d  = phase_q;
		tries_d  = tries_q;
		wait_d   = wait_q;
		bytes_d  = bytes_q;
		abl_d    = abl_q;
		dev_d    = dev_q;
		reg_d    = reg_q;
		dir_d    = dir_q;
		failed_d = failed_q;
		has_res  = 1'b0;
		res      = '0;

		lim_tries = (retry_limit_q == 3'd0) ? 3'd1 : retry_limit_q;
		lim_to    = (timeout_ticks_q == 8'd0) ? 8'd1 : timeout_ticks_q;
		wait_inc  = (wait_q == 8'hFF) ? wait_q : wait_q + 8'd1;
		tries_dec = (tries_q == 3'd0) ? 3'd0 : tries_q - 3'd1;
		bytes_dec = bytes_q - 1'b1;
		abl_dec   = abl_q - 2'd1;
		waiting   = (phase_q != PH_IDLE) && (phase_q != PH_NEED);
		fire      = 1'b0;
		timed     = 1'b0;
		sel_fail  = 1'b0;
		fail      = 1'b0;
		rd        = (phase_q == PH_SELR_START) || (phase_q == PH_SELR_ADDR);

		unique case (item_s1.kind)
			KIND_CMD: begin
				if (phase_q == PH_IDLE) begin
					dir_d    = item_s1.is_read;
					dev_d    = item_s1.dev_addr;
					abl_d    = item_s1.addr_bytes[1] ? 2'd2 : 2'd1;
					reg_d    = item_s1.reg_addr;
					bytes_d  = item_s1.length;
					tries_d  = lim_tries;
					failed_d = 1'b0;
					phase_d  = PH_SELW_START;
					wait_d   = '0;
					has_res  = 1'b1;
					res.action = ACT_START;
				end
			end
			KIND_BYTE: begin
				if (phase_q == PH_NEED) begin
					phase_d  = PH_TX;
					wait_d   = '0;
					has_res  = 1'b1;
					res.action      = ACT_SEND;
					res.action_byte = item_s1.write_byte;
				end
			end
			KIND_DONE: begin
				fire = waiting;
			end
			KIND_TICK: begin
				if (waiting) begin
					wait_d = wait_inc;
					if (wait_inc >= lim_to) begin
						fire  = 1'b1;
						timed = 1'b1;
					end
				end
			end
		endcase

		st = timed ? 8'h00 : (item_s1.bus_status & ST_MASK);

		if (fire) begin
			has_res = 1'b1;
			wait_d  = '0;
			unique case (phase_q)
				PH_SELW_START, PH_SELR_START: begin
					if (timed || (st != ST_START && st != ST_REP_START)) begin
						sel_fail = 1'b1;
					end else begin
						phase_d = rd ? PH_SELR_ADDR : PH_SELW_ADDR;
						res.action      = ACT_SEND;
						res.action_byte = {dev_q, rd};
					end
				end
				PH_SELW_ADDR: begin
					if (timed || st != ST_TX_ADR_ACK) begin
						sel_fail = 1'b1;
					end else begin
						phase_d = PH_REG;
						res.action      = ACT_SEND;
						res.action_byte = (abl_q == 2'd2) ? reg_q[15:8] : reg_q[7:0];
					end
				end
				PH_SELR_ADDR: begin
					if (timed || st != ST_RX_ADR_ACK) begin
						sel_fail = 1'b1;
					end else if (bytes_q == '0) begin
						phase_d = PH_FINAL_STOP;
						res.action = ACT_STOP;
					end else begin
						phase_d = PH_RX;
						res.action = (bytes_q > 1) ? ACT_RX_ACK : ACT_RX_NACK;
					end
				end
				PH_SELW_STOP, PH_SELR_STOP: begin
					phase_d = (phase_q == PH_SELR_STOP) ? PH_SELR_START : PH_SELW_START;
					res.action = ACT_START;
				end
				PH_REG: begin
					if (timed || st != ST_TX_DATA_ACK) begin
						fail = 1'b1;
					end else begin
						abl_d = abl_dec;
						if (abl_dec == 2'd1) begin
							res.action      = ACT_SEND;
							res.action_byte = reg_q[7:0];
						end else if (dir_q) begin
							tries_d = lim_tries;
							phase_d = PH_SELR_START;
							res.action = ACT_START;
						end else if (bytes_q == '0) begin
							phase_d = PH_FINAL_STOP;
							res.action = ACT_STOP;
						end else begin
							phase_d = PH_NEED;
							res.need_data = 1'b1;
						end
					end
				end
				PH_RX: begin
					if (timed || st != ((bytes_q > 1) ? ST_RX_DATA_ACK : ST_RX_DATA_NACK)) begin
						fail = 1'b1;
					end else begin
						bytes_d      = bytes_dec;
						res.rx_valid = 1'b1;
						res.rx_data  = item_s1.bus_rx_byte;
						if (bytes_dec == '0) begin
							phase_d = PH_FINAL_STOP;
							res.action = ACT_STOP;
						end else begin
							res.action = (bytes_dec > 1) ? ACT_RX_ACK : ACT_RX_NACK;
						end
					end
				end
				PH_TX: begin
					if (timed || st != ST_TX_DATA_ACK) begin
						fail = 1'b1;
					end else begin
						bytes_d = bytes_dec;
						if (bytes_dec == '0) begin
							phase_d = PH_FINAL_STOP;
							res.action = ACT_STOP;
						end else begin
							phase_d = PH_NEED;
							res.need_data = 1'b1;
						end
					end
				end
				PH_FINAL_STOP: begin
					phase_d = PH_IDLE;
					res.done_res = 1'b1;
					res.ok       = !failed_q;
				end
				default: begin
					has_res = 1'b0;
					wait_d  = wait_q;
				end
			endcase

			if (sel_fail) begin
				tries_d    = tries_dec;
				res.action = ACT_STOP;
				if (tries_dec == 3'd0) begin
					fail = 1'b1;
				end else begin
					phase_d = rd ? PH_SELR_STOP : PH_SELW_STOP;
				end
			end
			if (fail) begin
				failed_d   = 1'b1;
				phase_d    = PH_FINAL_STOP;
				res        = '0;
				res.action = ACT_STOP;
			end
		end
	end

endmodule

[hdl/irts_checker.sv]
// ----------------------------------------------------------------------------
// irts_checker
// Port-level checks on the I2C register transaction sequencer.
// ----------------------------------------------------------------------------
module irts_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input irts_pkg::out_item_t out_data
);
	import irts_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	a_rx_action: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.rx_valid |->
			(out_data.action == ACT_RX_ACK || out_data.action == ACT_RX_NACK ||
			 out_data.action == ACT_STOP) && !out_data.done_res)
		else $error("read byte with unexpected action");

	a_need_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.need_data |->
			out_data.action == ACT_NONE && !out_data.done_res && !out_data.rx_valid)
		else $error("payload request mixed with other result");

	a_done_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.done_res || out_data.ok) |->
			out_data.done_res && out_data.action == ACT_NONE && !out_data.need_data)
		else $error("malformed done result");

	a_reset_idle: assert property (@(posedge clk)
		!arst_n |=> !out_valid && !in_stall)
		else $error("activity during reset");

endmodule

bind i2c_register_transaction_sequencer irts_checker u_irts_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

[tb/sv/i2c_register_transaction_sequencer_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_register_transaction_sequencer_tb
// Acts as host and bus engine around the sequencer. It sends commands, status
// returns, ticks and payload bytes. Most of them form legal transactions, and
// wrong codes, timeouts and random traffic are mixed in. A transaction model
// in the scoreboard predicts every bus action and checks the results in order.
// ----------------------------------------------------------------------------
module i2c_register_transaction_sequencer_tb;
	import irts_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int PHASE_ITEMS = 275;

	class bus_action_board;
		bit [2:0]  retry_limit = RETRY_RESET;
		bit [7:0]  timeout_ticks = TIMEOUT_RESET;
		phase_t    phase = PH_IDLE;
		bit [2:0]  tries_left;
		bit [7:0]  wait_count;
		bit [15:0] bytes_left;
		bit [1:0]  addr_left;
		bit [6:0]  device;
		bit [15:0] reg_index;
		bit        rd_dir;
		bit        failed;
		out_item_t pending_actions[$];
		int        errors;

		function void set_reg(cfg_idx_t idx, bit [7:0] value);
			if (idx == CFG_RETRY_LIMIT) begin
				retry_limit = value[2:0];
			end else begin
				timeout_ticks = value;
			end
		endfunction

		function bit waiting();
			return phase != PH_IDLE && phase != PH_NEED;
		endfunction

		function bit [7:0] tick_limit();
			return timeout_ticks == 8'd0 ? 8'd1 : timeout_ticks;
		endfunction

		function bit [2:0] attempts();
			return retry_limit == 3'd0 ? 3'd1 : retry_limit;
		endfunction

		function void queue_action(act_t act, bit [7:0] tx_byte = 8'h00, bit rxv = 1'b0,
				bit [7:0] rxd = 8'h00, bit need = 1'b0, bit fin = 1'b0, bit okv = 1'b0);
			out_item_t r;
			r.action = act;
			r.action_byte = tx_byte;
			r.rx_valid = rxv;
			r.rx_data = rxd;
			r.need_data = need;
			r.done_res = fin;
			r.ok = okv;
			pending_actions.push_back(r);
		endfunction

		function void enter(phase_t p);
			phase = p;
			wait_count = 8'd0;
		endfunction

		function void abort_txn();
			failed = 1'b1;
			enter(PH_FINAL_STOP);
			queue_action(ACT_STOP);
		endfunction

		function void selection_failed();
			bit second;
			second = phase == PH_SELR_START || phase == PH_SELR_ADDR;
			if (tries_left != 3'd0)
				tries_left--;
			if (tries_left == 3'd0) begin
				abort_txn();
			end else begin
				enter(second ? PH_SELR_STOP : PH_SELW_STOP);
				queue_action(ACT_STOP);
			end
		endfunction

		function void next_receive(bit rxv, bit [7:0] rxd);
			if (bytes_left == 16'd0) begin
				enter(PH_FINAL_STOP);
				queue_action(ACT_STOP, 8'h00, rxv, rxd);
			end else begin
				enter(PH_RX);
				queue_action(bytes_left > 16'd1 ? ACT_RX_ACK : ACT_RX_NACK, 8'h00, rxv, rxd);
			end
		endfunction

		function void bus_finished(bit timed, bit [7:0] status, bit [7:0] rx);
			bit [7:0] code;
			bit [7:0] want;
			bit       rd;
			code = status & ST_MASK;
			rd = phase == PH_SELR_START;
			case (phase)
				PH_SELW_START, PH_SELR_START: begin
					if (timed || (code != ST_START && code != ST_REP_START)) begin
						selection_failed();
					end else begin
						enter(rd ? PH_SELR_ADDR : PH_SELW_ADDR);
						queue_action(ACT_SEND, {device, rd});
					end
				end
				PH_SELW_ADDR: begin
					if (timed || code != ST_TX_ADR_ACK) begin
						selection_failed();
					end else begin
						enter(PH_REG);
						queue_action(ACT_SEND, addr_left == 2'd2 ? reg_index[15:8] : reg_index[7:0]);
					end
				end
				PH_SELR_ADDR: begin
					if (timed || code != ST_RX_ADR_ACK) begin
						selection_failed();
					end else begin
						next_receive(1'b0, 8'h00);
					end
				end
				PH_SELW_STOP, PH_SELR_STOP: begin
					enter(phase == PH_SELR_STOP ? PH_SELR_START : PH_SELW_START);
					queue_action(ACT_START);
				end
				PH_REG: begin
					if (timed || code != ST_TX_DATA_ACK) begin
						abort_txn();
					end else begin
						addr_left--;
						if (addr_left == 2'd1) begin
							enter(PH_REG);
							queue_action(ACT_SEND, reg_index[7:0]);
						end else if (rd_dir) begin
							tries_left = attempts();
							enter(PH_SELR_START);
							queue_action(ACT_START);
						end else if (bytes_left == 16'd0) begin
							enter(PH_FINAL_STOP);
							queue_action(ACT_STOP);
						end else begin
							enter(PH_NEED);
							queue_action(ACT_NONE, 8'h00, 1'b0, 8'h00, 1'b1);
						end
					end
				end
				PH_RX: begin
					want = bytes_left > 16'd1 ? ST_RX_DATA_ACK : ST_RX_DATA_NACK;
					if (timed || code != want) begin
						abort_txn();
					end else begin
						bytes_left--;
						next_receive(1'b1, rx);
					end
				end
				PH_TX: begin
					if (timed || code != ST_TX_DATA_ACK) begin
						abort_txn();
					end else begin
						bytes_left--;
						if (bytes_left == 16'd0) begin
							enter(PH_FINAL_STOP);
							queue_action(ACT_STOP);
						end else begin
							enter(PH_NEED);
							queue_action(ACT_NONE, 8'h00, 1'b0, 8'h00, 1'b1);
						end
					end
				end
				PH_FINAL_STOP: begin
					enter(PH_IDLE);
					queue_action(ACT_NONE, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1, !failed);
				end
				default: ;
			endcase
		endfunction

		// returns 1 when the transfer was acted on rather than ignored
		function bit take_event(in_item_t it);
			bit used;
			used = 1'b0;
			case (it.kind)
				KIND_CMD: begin
					if (phase == PH_IDLE) begin
						rd_dir = it.is_read;
						device = it.dev_addr;
						addr_left = it.addr_bytes[1] ? 2'd2 : 2'd1;
						reg_index = it.reg_addr;
						bytes_left = it.length;
						tries_left = attempts();
						failed = 1'b0;
						enter(PH_SELW_START);
						queue_action(ACT_START);
						used = 1'b1;
					end
				end
				KIND_BYTE: begin
					if (phase == PH_NEED) begin
						enter(PH_TX);
						queue_action(ACT_SEND, it.write_byte);
						used = 1'b1;
					end
				end
				KIND_DONE: begin
					if (waiting()) begin
						bus_finished(1'b0, it.bus_status, it.bus_rx_byte);
						used = 1'b1;
					end
				end
				default: begin
					if (waiting()) begin
						if (wait_count != 8'hFF)
							wait_count++;
						if (wait_count >= tick_limit())
							bus_finished(1'b1, 8'h00, 8'h00);
						used = 1'b1;
					end
				end
			endcase
			return used;
		endfunction

		function void compare(string field, logic [15:0] want, logic [15:0] got);
			if (got !== want) begin
				$error("%s: expected %0h, actual %0h", field, want, got);
				errors++;
			end
		endfunction

		function void match_action(out_item_t got);
			out_item_t want;
			if (pending_actions.size() == 0) begin
				$error("result: expected none, actual %0h", got);
				errors++;
				return;
			end
			want = pending_actions.pop_front();
			compare("action", want.action, got.action);
			compare("action_byte", want.action_byte, got.action_byte);
			compare("rx_valid", want.rx_valid, got.rx_valid);
			compare("rx_data", want.rx_data, got.rx_data);
			compare("need_data", want.need_data, got.need_data);
			compare("done_res", want.done_res, got.done_res);
			compare("ok", want.ok, got.ok);
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	in_item_t   in_data = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	out_item_t  out_data;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	cfg_idx_t   cfg_index = CFG_RETRY_LIMIT;
	logic [7:0] cfg_data = 8'h00;

	bus_action_board board = new;
	int idle_pct = 0;
	int stall_pct = 0;
	int used_items = 0;
	int quiet_cycles = 0;

	int plan_tries[6] = '{7, 1, 0, 2, 5, 7};
	int plan_ticks[6] = '{255, 1, 0, 3, 12, 50};
	int plan_idle[6]  = '{0, 65, 0, 30, 65, 0};
	int plan_stall[6] = '{0, 0, 65, 30, 0, 65};

	i2c_register_transaction_sequencer DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_stall <= $urandom_range(99) < stall_pct;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.match_action(out_data);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("i2c_register_transaction_sequencer: mismatch");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic in_item_t noise_item();
		logic [95:0] raw;
		raw = {$urandom, $urandom, $urandom};
		return in_item_t'(raw[$bits(in_item_t)-1:0]);
	endfunction

	function automatic in_item_t tick_item();
		in_item_t it;
		it = noise_item();
		it.kind = KIND_TICK;
		return it;
	endfunction

	function automatic in_item_t byte_item();
		in_item_t it;
		it = noise_item();
		it.kind = KIND_BYTE;
		return it;
	endfunction

	function automatic in_item_t command(bit rd, bit [6:0] dev, bit [1:0] ab, bit [15:0] ra,
			bit [15:0] len);
		in_item_t it;
		it = noise_item();
		it.kind = KIND_CMD;
		it.is_read = rd;
		it.dev_addr = dev;
		it.addr_bytes = ab;
		it.reg_addr = ra;
		it.length = len;
		return it;
	endfunction

	// status return for the pending bus action; a bad one flips one code bit
	function automatic in_item_t bus_reply(bit good);
		in_item_t   it;
		logic [7:0] code;
		it = noise_item();
		it.kind = KIND_DONE;
		case (board.phase)
			PH_SELW_START, PH_SELR_START: code = $urandom_range(1) ? ST_START : ST_REP_START;
			PH_SELW_ADDR: code = ST_TX_ADR_ACK;
			PH_SELR_ADDR: code = ST_RX_ADR_ACK;
			PH_REG, PH_TX: code = ST_TX_DATA_ACK;
			PH_RX: code = board.bytes_left > 16'd1 ? ST_RX_DATA_ACK : ST_RX_DATA_NACK;
			default: code = 8'($urandom);
		endcase
		if (!good)
			code = code ^ (8'h08 << $urandom_range(4));
		it.bus_status = {code[7:3], 3'($urandom)};
		return it;
	endfunction

	function automatic in_item_t next_item();
		in_item_t  it;
		int        pick;
		bit [15:0] len;
		pick = $urandom_range(99);
		if (pick < 15) begin
			it = noise_item();
		end else if (board.phase == PH_IDLE) begin
			pick = $urandom_range(99);
			if (pick < 60)
				len = 16'($urandom_range(3));
			else if (pick < 95)
				len = 16'($urandom_range(16, 4));
			else
				len = 16'($urandom);
			it = command(1'($urandom), 7'($urandom), 2'($urandom), 16'($urandom), len);
		end else if (board.phase == PH_NEED) begin
			it = byte_item();
		end else begin
			pick = $urandom_range(99);
			if (pick < 4)
				it = bus_reply(1'b0);
			else if (pick < 12)
				it = tick_item();
			else
				it = bus_reply(1'b1);
		end
		return it;
	endfunction

	task automatic push(in_item_t it);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (in_stall !== 1'b0);
		if (board.take_event(it))
			used_items++;
	endtask

	task automatic finish_txn(bit good);
		while (board.phase != PH_IDLE)
			push(board.phase == PH_NEED ? byte_item() : bus_reply(good));
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (board.pending_actions.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_settings(bit [2:0] tries, bit [7:0] ticks);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_RETRY_LIMIT;
		cfg_data <= {5'd0, tries};
		do @(posedge clk); while (cfg_ready !== 1'b1);
		board.set_reg(CFG_RETRY_LIMIT, {5'd0, tries});
		cfg_index <= CFG_TIMEOUT_TICKS;
		cfg_data <= ticks;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		board.set_reg(CFG_TIMEOUT_TICKS, ticks);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int     target;
		phase_t seen;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// stray events while idle
		push(tick_item());
		push(bus_reply(1'b1));
		push(byte_item());
		// one-byte address write, then a command while busy
		push(command(1'b0, 7'h7F, 2'd0, 16'hFFFF, 16'd1));
		push(command(1'b1, 7'h00, 2'd3, 16'h0000, 16'hFFFF));
		finish_txn(1'b1);
		// two-byte read with one failed selection
		push(command(1'b1, 7'h00, 2'd3, 16'h0000, 16'd2));
		push(bus_reply(1'b0));
		finish_txn(1'b1);
		// zero-length read
		push(command(1'b1, 7'h2A, 2'd1, 16'h5AA5, 16'd0));
		finish_txn(1'b1);
		settle();

		for (int i = 0; i < 6; i++) begin
			write_settings(3'(plan_tries[i]), 8'(plan_ticks[i]));
			idle_pct = plan_idle[i];
			stall_pct = plan_stall[i];
			target = used_items + PHASE_ITEMS;
			while (used_items < target) begin
				if (board.waiting() && board.tick_limit() <= 8'd60 && $urandom_range(99) < 2) begin
					// tick until the pending action times out
					seen = board.phase;
					while (board.phase == seen)
						push(tick_item());
				end else begin
					push(next_item());
				end
			end
			finish_txn(1'b0);
			settle();
		end

		if (board.errors == 0) begin
			$display("i2c_register_transaction_sequencer: match");
		end else begin
			$display("i2c_register_transaction_sequencer: mismatch");
		end
		$finish;
	end
endmodule
